>>> hdl/tfn_pkg.sv
package tfn_pkg;

   localparam int COORD_BITS_DEF       = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int SCALE_BITS           = 30;
   localparam int EDGE_BITS            = SCALE_BITS + 1;
   localparam int PROD_BITS            = 2 * EDGE_BITS;
   localparam int CMAG_BITS            = PROD_BITS - 1;
   localparam int SQ_BITS              = 2 * SCALE_BITS;
   localparam int SUM_BITS             = SQ_BITS + 2;
   localparam int ROOT_BITS            = SUM_BITS / 2;
   localparam int NORM_BITS            = 16;
   localparam int NORM_MAX             = 32767;

   typedef logic [SCALE_BITS-1:0] mag_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       degenerate;
   } side_type;

endpackage

>>> hdl/triangle_face_normal_unit.sv
// Triangle face normal unit.
// The req channel carries one triangle per item: nine signed vertex coordinates
// v0_x .. v2_z, each COORD_BITS wide with 16 fraction bits. The rsp channel returns
// one item per triangle: the unit normal of (v2-v0) x (v1-v0) in signed fixed point
// with NORMAL_FRAC_BITS fraction bits on rsp_tdata, and on rsp_tuser a degenerate
// flag that is set, with a zero normal, when the cross product is zero.
// The unit is a single pipeline that takes one item in every cycle while the output
// is not stalled. Its stages are edges and cross product, rescaling and the squared
// length, the square root (one root bit per stage), the three parallel divisions
// (one quotient bit per stage) and the output register.
// When rsp_tready is low while a result is held, the whole pipeline and req_tready
// hold; nothing is lost or repeated. A free output register lets items advance.
// Reset clears all valid bits; no item is in flight afterwards.
module triangle_face_normal_unit
   import tfn_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero padding.
   input  logic [((9 * COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // norm_x, norm_y, norm_z.
   output logic [47:0]                                 rsp_tdata,
   // degenerate.
   output logic                                        rsp_tuser
);

   localparam int QW = (NORMAL_FRAC_BITS + 1 > NORM_BITS) ? NORMAL_FRAC_BITS + 1 : NORM_BITS;

   logic                               en;
   logic signed [COORD_BITS-1:0]       coord [0:8];
   logic                               x_valid, s_valid, r_valid, d_valid;
   logic signed [PROD_BITS-1:0]        cprod [0:2];
   logic [SUM_BITS-1:0]                sum;
   mag_type                            s_mag [0:2];
   mag_type                            r_mag [0:2];
   side_type                           s_side, r_side, d_side;
   logic [ROOT_BITS-1:0]               root;
   logic [NORMAL_FRAC_BITS:0]          quot [0:2];
   logic [QW-1:0]                      sat [0:2];
   logic [NORM_BITS-1:0]               norm_in [0:2];
   logic [NORM_BITS-1:0]               norm_ff [0:2];
   logic                               deg_ff;
   logic                               rsp_tvalid_ff;

   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         coord[k] = req_tdata[k*COORD_BITS +: COORD_BITS];
      end
   end

   tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .coord     (coord),
      .out_valid (x_valid),
      .cprod     (cprod)
   );

   tfn_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_valid),
      .cprod     (cprod),
      .out_valid (s_valid),
      .sum       (sum),
      .mag       (s_mag),
      .side      (s_side)
   );

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .sum       (sum),
      .in_mag    (s_mag),
      .in_side   (s_side),
      .out_valid (r_valid),
      .root      (root),
      .out_mag   (r_mag),
      .out_side  (r_side)
   );

   tfn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .len       (root),
      .in_mag    (r_mag),
      .in_side   (r_side),
      .out_valid (d_valid),
      .quot      (quot),
      .out_side  (d_side)
   );

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         sat[n] = QW'(quot[n]);
         if (sat[n] > (QW'(1) << NORMAL_FRAC_BITS)) begin
            sat[n] = QW'(1) << NORMAL_FRAC_BITS;
         end
         if (sat[n] > QW'(NORM_MAX)) begin
            sat[n] = QW'(NORM_MAX);
         end
         if (d_side.degenerate) begin
            norm_in[n] = '0;
         end else if (d_side.neg[n]) begin
            norm_in[n] = NORM_BITS'(-sat[n]);
         end else begin
            norm_in[n] = NORM_BITS'(sat[n]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         norm_ff <= norm_in;
         deg_ff  <= d_side.degenerate;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {norm_ff[2], norm_ff[1], norm_ff[0]};
   assign rsp_tuser  = deg_ff;

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && deg_ff |-> (norm_ff[0] == '0 && norm_ff[1] == '0 && norm_ff[2] == '0))
      else $error("degenerate item carries a nonzero normal");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(d_valid) && $stable(d_side))
      else $error("pipeline moved while the output was stalled");

   a_sat : assert property (@(posedge clock) disable iff (reset)
      d_valid && !d_side.degenerate |->
         (sat[0] <= (QW'(1) << NORMAL_FRAC_BITS) && sat[1] <= (QW'(1) << NORMAL_FRAC_BITS)
          && sat[2] <= (QW'(1) << NORMAL_FRAC_BITS)))
      else $error("normal component above one");

endmodule

>>> hdl/tfn_cross.sv
module tfn_cross
   import tfn_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [COORD_BITS-1:0]        coord [0:8],
   output logic                                out_valid,
   output logic signed [PROD_BITS-1:0]         cprod [0:2]
);

   localparam int EXTRA = (COORD_BITS > SCALE_BITS) ? COORD_BITS - SCALE_BITS : 1;
   localparam int SHW   = $clog2(EXTRA + 1);

   logic                          v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [COORD_BITS:0]    e_ff [0:5];
   logic signed [COORD_BITS:0]    e_in [0:5];
   logic signed [EDGE_BITS-1:0]   s_ff [0:5];
   logic signed [EDGE_BITS-1:0]   s_in [0:5];
   logic signed [PROD_BITS-1:0]   p_ff [0:5];
   logic signed [PROD_BITS-1:0]   c_ff [0:2];
   logic [COORD_BITS:0]           emag [0:5];
   logic [COORD_BITS:0]           eor;
   logic [SHW-1:0]                eshift;
   mag_type                       smag [0:5];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e_in[k]     = (COORD_BITS+1)'(coord[3+k]) - (COORD_BITS+1)'(coord[k]);
         e_in[3+k]   = (COORD_BITS+1)'(coord[6+k]) - (COORD_BITS+1)'(coord[k]);
      end
   end

   always_comb begin
      eor = '0;
      for (int k = 0; k < 6; k++) begin
         emag[k] = e_ff[k][COORD_BITS] ? (COORD_BITS+1)'(-e_ff[k]) : (COORD_BITS+1)'(e_ff[k]);
         eor     = eor | emag[k];
      end
      eshift = '0;
      for (int i = SCALE_BITS; i <= COORD_BITS; i++) begin
         if (eor[i]) begin
            eshift = SHW'(i - SCALE_BITS + 1);
         end
      end
      for (int k = 0; k < 6; k++) begin
         smag[k] = SCALE_BITS'(emag[k] >> eshift);
         s_in[k] = e_ff[k][COORD_BITS] ? -$signed({1'b0, smag[k]}) : $signed({1'b0, smag[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= e_in;
         s_ff    <= s_in;
         p_ff[0] <= s_ff[4] * s_ff[2];
         p_ff[1] <= s_ff[5] * s_ff[1];
         p_ff[2] <= s_ff[5] * s_ff[0];
         p_ff[3] <= s_ff[3] * s_ff[2];
         p_ff[4] <= s_ff[3] * s_ff[1];
         p_ff[5] <= s_ff[4] * s_ff[0];
         c_ff[0] <= p_ff[0] - p_ff[1];
         c_ff[1] <= p_ff[2] - p_ff[3];
         c_ff[2] <= p_ff[4] - p_ff[5];
      end
   end

   assign out_valid = v4_ff;
   assign cprod     = c_ff;

endmodule

>>> hdl/tfn_scale.sv
module tfn_scale
   import tfn_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [PROD_BITS-1:0] cprod [0:2],
   output logic                        out_valid,
   output logic [SUM_BITS-1:0]         sum,
   output mag_type                     mag [0:2],
   output side_type                    side
);

   logic                   v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   logic [CMAG_BITS-1:0]   m5_ff [0:2];
   logic [CMAG_BITS-1:0]   m6_ff [0:2];
   logic [CMAG_BITS-1:0]   m5_or;
   logic [4:0]             sh_in, sh_ff;
   logic [2:0]             n5_ff, n6_ff, n7_ff, n8_ff, n9_ff;
   mag_type                m7_ff [0:2];
   mag_type                m8_ff [0:2];
   mag_type                m9_ff [0:2];
   logic [SQ_BITS-1:0]     q8_ff [0:2];
   logic [SUM_BITS-1:0]    sum_ff;

   always_comb begin
      m5_or = m5_ff[0] | m5_ff[1] | m5_ff[2];
      sh_in = '0;
      for (int i = SCALE_BITS; i < CMAG_BITS; i++) begin
         if (m5_or[i]) begin
            sh_in = 5'(i - SCALE_BITS + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            n5_ff[k] <= cprod[k][PROD_BITS-1];
            m5_ff[k] <= cprod[k][PROD_BITS-1] ? CMAG_BITS'(-cprod[k]) : CMAG_BITS'(cprod[k]);
            m7_ff[k] <= SCALE_BITS'(m6_ff[k] >> sh_ff);
            q8_ff[k] <= SQ_BITS'(m7_ff[k]) * SQ_BITS'(m7_ff[k]);
         end
         m6_ff  <= m5_ff;
         sh_ff  <= sh_in;
         n6_ff  <= n5_ff;
         n7_ff  <= n6_ff;
         n8_ff  <= n7_ff;
         n9_ff  <= n8_ff;
         m8_ff  <= m7_ff;
         m9_ff  <= m8_ff;
         sum_ff <= SUM_BITS'(q8_ff[0]) + SUM_BITS'(q8_ff[1]) + SUM_BITS'(q8_ff[2]);
      end
   end

   assign out_valid       = v9_ff;
   assign sum             = sum_ff;
   assign mag             = m9_ff;
   assign side.neg        = n9_ff;
   assign side.degenerate = (sum_ff == '0);

endmodule

>>> hdl/tfn_sqrt.sv
module tfn_sqrt
   import tfn_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [SUM_BITS-1:0]   sum,
   input  mag_type               in_mag [0:2],
   input  side_type              in_side,
   output logic                  out_valid,
   output logic [ROOT_BITS-1:0]  root,
   output mag_type               out_mag [0:2],
   output side_type              out_side
);

   logic                  v_ff    [0:ROOT_BITS];
   logic [SUM_BITS-1:0]   rem_ff  [0:ROOT_BITS];
   logic [ROOT_BITS-1:0]  root_ff [0:ROOT_BITS];
   mag_type               mag_ff  [0:ROOT_BITS][0:2];
   side_type              side_ff [0:ROOT_BITS];

   always_comb begin
      v_ff[0]    = in_valid;
      rem_ff[0]  = sum;
      root_ff[0] = '0;
      mag_ff[0]  = in_mag;
      side_ff[0] = in_side;
   end

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
      localparam int B = ROOT_BITS - 1 - k;
      logic [SUM_BITS-1:0] trial;
      logic                take;

      assign trial = (SUM_BITS'(root_ff[k]) << (B + 1)) + (SUM_BITS'(1) << (2 * B));
      assign take  = (rem_ff[k] >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= take ? rem_ff[k] - trial : rem_ff[k];
            root_ff[k+1] <= take ? root_ff[k] | (ROOT_BITS'(1) << B) : root_ff[k];
            mag_ff[k+1]  <= mag_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[ROOT_BITS];
   assign root      = root_ff[ROOT_BITS];
   assign out_mag   = mag_ff[ROOT_BITS];
   assign out_side  = side_ff[ROOT_BITS];

endmodule

>>> hdl/tfn_div.sv
module tfn_div
   import tfn_pkg::*;
#(
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [ROOT_BITS-1:0]         len,
   input  mag_type                      in_mag [0:2],
   input  side_type                     in_side,
   output logic                         out_valid,
   output logic [NORMAL_FRAC_BITS:0]    quot [0:2],
   output side_type                     out_side
);

   localparam int STEPS = NORMAL_FRAC_BITS + 1;

   logic                        v_ff    [0:STEPS];
   logic [SUM_BITS-1:0]         rem_ff  [0:STEPS][0:2];
   logic [NORMAL_FRAC_BITS:0]   q_ff    [0:STEPS][0:2];
   logic [ROOT_BITS-1:0]        len_ff  [0:STEPS];
   side_type                    side_ff [0:STEPS];

   always_comb begin
      v_ff[0]    = in_valid;
      len_ff[0]  = len;
      side_ff[0] = in_side;
      for (int n = 0; n < 3; n++) begin
         rem_ff[0][n] = (SUM_BITS'(in_mag[n]) << NORMAL_FRAC_BITS) + SUM_BITS'(len >> 1);
         q_ff[0][n]   = '0;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = STEPS - 1 - k;
      logic [SUM_BITS-1:0] dsh;

      assign dsh = SUM_BITS'(len_ff[k]) << B;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int n = 0; n < 3; n++) begin
               if (rem_ff[k][n] >= dsh) begin
                  rem_ff[k+1][n] <= rem_ff[k][n] - dsh;
                  q_ff[k+1][n]   <= q_ff[k][n] | ((NORMAL_FRAC_BITS+1)'(1) << B);
               end else begin
                  rem_ff[k+1][n] <= rem_ff[k][n];
                  q_ff[k+1][n]   <= q_ff[k][n];
               end
            end
            len_ff[k+1]  <= len_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = v_ff[STEPS];
   assign quot      = q_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule
